// ===== rtl/core/smx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;

    // Kind of work the back end carries out for one queued item
    typedef logic [1:0] t_op;
    localparam t_op OP_TABLE = 2'd0;
    localparam t_op OP_SCORE = 2'd1;
    localparam t_op OP_LAST  = 2'd2;

    localparam int unsigned TAB_AW   = 8;
    localparam int unsigned TAB_DW   = 17;
    localparam int unsigned SCORE_W  = 8;
    localparam int unsigned SHIFT_W  = 4;
    localparam int unsigned PROB_W   = 7;
    // entry << (out_shift + 1) plus the row sum stays below 2^34
    localparam int unsigned NUM_W    = 34;

    localparam logic [SHIFT_W-1:0]        SHIFT_RST = 4'd7;
    localparam logic signed [SCORE_W-1:0] MAX_RST   = -8'sd128;
    localparam logic [PROB_W-1:0]         PROB_MAX  = 7'd127;

    typedef struct packed {
        t_op                        op;
        logic [TAB_AW-1:0]          index;
        logic [TAB_DW-1:0]          value;
        logic signed [SCORE_W-1:0]  score;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/core/smx_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface smx_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [7:0]         table_index;
    logic [16:0]        table_value;
    logic signed [7:0]  score;
    logic               row_end;

    modport source (output valid, action, table_index, table_value, score, row_end,
                    input ready);
    modport sink   (input valid, action, table_index, table_value, score, row_end,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/smx_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface smx_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] probability;
    logic       last_of_row;
    logic       row_overflow;

    modport source (output valid, probability, last_of_row, row_overflow, input ready);
    modport sink   (input valid, probability, last_of_row, row_overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/smx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smx_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    smx_in_if.sink             i_in,
    output smx_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_pop
);

    smx_pkg::t_cmd r_slot [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          w_push;
    smx_pkg::t_cmd w_cmd;

    // Classify the incoming beat
    always_comb begin
        w_cmd.index = i_in.table_index;
        w_cmd.value = i_in.table_value;
        w_cmd.score = i_in.score;
        if (!i_in.action) begin
            w_cmd.op = smx_pkg::OP_TABLE;
        end else if (i_in.row_end) begin
            w_cmd.op = smx_pkg::OP_LAST;
        end else begin
            w_cmd.op = smx_pkg::OP_SCORE;
        end
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign w_push      = i_in.valid && i_in.ready;
    assign o_cmd       = r_slot[r_rd];
    assign o_cmd_valid = (r_cnt != 2'd0);

    // Two-entry queue toward the back end
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/smx_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smx_back #(
    parameter int unsigned ROW_LEN = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire smx_pkg::t_cmd                 i_cmd,
    input  wire logic                          i_cmd_valid,
    output logic                               o_cmd_pop,
    input  wire logic [smx_pkg::SHIFT_W-1:0]   i_out_shift,
    smx_out_if.source                          o_out
);

    localparam int unsigned AW    = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
    localparam int unsigned CNT_W = $clog2(ROW_LEN + 1);
    localparam int unsigned SUM_W = smx_pkg::TAB_DW + $clog2(ROW_LEN);
    localparam int unsigned DV_W  = SUM_W + 8;
    localparam int unsigned CW    = (smx_pkg::NUM_W > DV_W) ? smx_pkg::NUM_W : DV_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SUM_ROW  = 4'd1;
    localparam logic [3:0] S_SUM_TAB  = 4'd2;
    localparam logic [3:0] S_SUM_ADD  = 4'd3;
    localparam logic [3:0] S_NRM_ROW  = 4'd4;
    localparam logic [3:0] S_NRM_TAB  = 4'd5;
    localparam logic [3:0] S_NRM_LOAD = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic signed [smx_pkg::SCORE_W-1:0] row_mem [ROW_LEN];
    logic [smx_pkg::TAB_DW-1:0]         tab_mem [2**smx_pkg::TAB_AW];

    logic [3:0]                          r_state;
    logic [CNT_W-1:0]                    r_cnt;
    logic [CNT_W-1:0]                    r_idx;
    logic signed [smx_pkg::SCORE_W-1:0]  r_max;
    logic                                r_ovf;
    logic [SUM_W-1:0]                    r_sum;
    logic signed [smx_pkg::SCORE_W-1:0]  r_row_q;
    logic [smx_pkg::TAB_DW-1:0]          r_tab_q;
    logic [CW-1:0]                       r_rem;
    logic [CW-1:0]                       r_dsh;
    logic [smx_pkg::PROB_W-1:0]          r_q;
    logic [2:0]                          r_k;
    logic                                r_ov;
    logic [smx_pkg::PROB_W-1:0]          r_o_prob;
    logic                                r_o_last;
    logic                                r_o_ovf;

    logic signed [8:0]                   w_off;
    logic signed [8:0]                   w_off_b;
    logic [smx_pkg::TAB_AW-1:0]          w_tab_addr;
    logic [CNT_W-1:0]                    w_idx_nx;
    logic                                w_last;
    logic                                w_ge;
    logic                                w_load;
    logic [4:0]                          w_sh;
    logic [CW-1:0]                       w_num;
    logic                                w_room;

    // Clip the offset from the row maximum and bias it into a table address
    assign w_off      = 9'(r_row_q) - 9'(r_max);
    assign w_off_b    = w_off + 9'sd128;
    assign w_tab_addr = (w_off < -9'sd128) ? '0 : w_off_b[7:0];

    assign w_idx_nx = r_idx + CNT_W'(1);
    assign w_last   = (w_idx_nx == r_cnt);
    assign w_ge     = (r_rem >= r_dsh);
    assign w_sh     = {1'b0, i_out_shift} + 5'd1;
    assign w_num    = (CW'(r_tab_q) << w_sh) + CW'(r_sum);
    assign w_room   = (r_cnt < CNT_W'(ROW_LEN));
    assign w_load   = (r_state == S_OUT) && (!r_ov || o_out.ready);

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // Memories: writes on pop, reads registered every cycle
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.op == smx_pkg::OP_TABLE)) begin
            tab_mem[i_cmd.index] <= i_cmd.value;
        end
        if (o_cmd_pop && (i_cmd.op != smx_pkg::OP_TABLE) && w_room) begin
            row_mem[r_cnt[AW-1:0]] <= i_cmd.score;
        end
        r_row_q <= row_mem[r_idx[AW-1:0]];
        r_tab_q <= tab_mem[w_tab_addr];
    end

    // Sequencer: store scores, sum the entries, then divide element by element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_max   <= smx_pkg::MAX_RST;
            r_ovf   <= 1'b0;
            r_sum   <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop && (i_cmd.op != smx_pkg::OP_TABLE)) begin
                        if (w_room) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                            if (i_cmd.score > r_max) begin
                                r_max <= i_cmd.score;
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_cmd.op == smx_pkg::OP_LAST) begin
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_state <= S_SUM_ROW;
                        end
                    end
                end
                S_SUM_ROW:  r_state <= S_SUM_TAB;
                S_SUM_TAB:  r_state <= S_SUM_ADD;
                S_SUM_ADD: begin
                    r_sum <= r_sum + SUM_W'(r_tab_q);
                    if (w_last) begin
                        r_idx   <= '0;
                        r_state <= S_NRM_ROW;
                    end else begin
                        r_idx   <= w_idx_nx;
                        r_state <= S_SUM_ROW;
                    end
                end
                S_NRM_ROW:  r_state <= S_NRM_TAB;
                S_NRM_TAB:  r_state <= S_NRM_LOAD;
                S_NRM_LOAD: r_state <= (r_sum == '0) ? S_OUT : S_DIV;
                S_DIV: begin
                    if (((r_k == 3'd7) && w_ge) || (r_k == 3'd0)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        if (w_last) begin
                            r_cnt   <= '0;
                            r_max   <= smx_pkg::MAX_RST;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= w_idx_nx;
                            r_state <= S_NRM_ROW;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Restoring divider: first step checks saturation, then seven quotient bits
    always_ff @(posedge i_clk) begin
        if (r_state == S_NRM_LOAD) begin
            r_rem <= w_num;
            r_dsh <= CW'({r_sum, 1'b0}) << 7;
            r_q   <= '0;
            r_k   <= 3'd7;
        end else if (r_state == S_DIV) begin
            if (r_k == 3'd7) begin
                if (w_ge) begin
                    r_q <= smx_pkg::PROB_MAX;
                end
            end else begin
                r_q <= {r_q[smx_pkg::PROB_W-2:0], w_ge};
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
            end
            r_dsh <= r_dsh >> 1;
            r_k   <= r_k - 3'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_prob <= r_q;
            r_o_last <= w_last;
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.probability  = r_o_prob;
    assign o_out.last_of_row  = r_o_last;
    assign o_out.row_overflow = r_o_ovf;

endmodule
`default_nettype wire

// ===== rtl/core/int8_row_softmax_lut.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Beat
// i_in      in   action, table_index, table_value, score, row_end (valid/ready)
// o_out     out  probability, last_of_row, row_overflow (valid/ready)
// i_cfg_*   in   out_shift write, taken on a rising edge with i_cfg_we high
//
// Table writes and plain scores are taken from the input queue while the back end idles.
// A row end starts a sum pass (row read, table read and add for each element), then
// per element two memory reads, load, up to eight divider steps and output follow.
// Reset is synchronous and active low; table and row memories need no clearing.
// A two-beat queue sits between front and back; the input stalls once both slots
// hold beats while the back end works a row or the output register waits on ready.
module int8_row_softmax_lut #(
    parameter int unsigned ROW_LEN = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    smx_in_if.sink                           i_in,
    smx_out_if.source                        o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [smx_pkg::SHIFT_W-1:0] i_cfg_wdata
);

    logic [smx_pkg::SHIFT_W-1:0] r_out_shift;
    smx_pkg::t_cmd               w_cmd;
    logic                        w_cmd_valid;
    logic                        w_cmd_pop;

    // Hold the output scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_shift <= smx_pkg::SHIFT_RST;
        end else if (i_cfg_we) begin
            r_out_shift <= i_cfg_wdata;
        end
    end

    smx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    smx_back #(
        .ROW_LEN (ROW_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_out_shift (r_out_shift),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
